[sv/qmm_pkg.sv]
package qmm_pkg;

  localparam int unsigned MOTORS = 4;

  // Battery sag compensation divides by this constant.
  localparam int unsigned SAG_DIVISOR = 3500;
  localparam logic [11:0] SAG_DIV_W   = 12'(SAG_DIVISOR);

  // floor(x / 3500) = (x * DQ_RECIP) >> DQ_SHIFT for any 16-bit x
  localparam logic [16:0] DQ_RECIP = 17'd76696;
  localparam int unsigned DQ_SHIFT = 28;

  // floor(x / 875) = (x * DR_RECIP) >> DR_SHIFT for any 24-bit x
  localparam logic [24:0] DR_RECIP = 25'd19634137;
  localparam int unsigned DR_SHIFT = 34;

  localparam logic [11:0] RST_THROTTLE_LIMIT   = 12'd1800;
  localparam logic [15:0] RST_BATTERY_FULL     = 16'd12600;
  localparam logic [15:0] RST_BATTERY_EMPTY    = 16'd9000;
  localparam logic [11:0] RST_MOTORS_ON_WIDTH  = 12'd1100;
  localparam logic [11:0] RST_MAX_WIDTH        = 12'd2000;
  localparam logic [11:0] RST_MOTORS_OFF_WIDTH = 12'd1000;
  localparam logic [15:0] RST_FRAME_PERIOD     = 16'd4000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_MIX     = 2'd1,
    OP_DISABLE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CFG_THROTTLE_LIMIT   = 3'd0,
    CFG_BATTERY_FULL     = 3'd1,
    CFG_BATTERY_EMPTY    = 3'd2,
    CFG_MOTORS_ON_WIDTH  = 3'd3,
    CFG_MAX_WIDTH        = 3'd4,
    CFG_MOTORS_OFF_WIDTH = 3'd5,
    CFG_FRAME_PERIOD     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] throttle_limit;
    logic [15:0] battery_full;
    logic [15:0] battery_empty;
    logic [11:0] motors_on_width;
    logic [11:0] max_width;
    logic [11:0] motors_off_width;
    logic [15:0] frame_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] throttle;
    logic [15:0] level;
    logic [11:0] roll;
    logic [11:0] pitch;
    logic [11:0] yaw;
  } item_t;

  // Raw mix (signed), sag correction magnitude and its sign per motor.
  typedef struct packed {
    logic [1:0]       op;
    logic [11:0]      thr;
    logic [3:0][14:0] w;
    logic [3:0][18:0] mag;
    logic [3:0]       neg;
    logic             comp;
  } mixed_t;

endpackage

[sv/qmm_mix_pipe.sv]
module qmm_mix_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  qmm_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  qmm_pkg::item_t up_item,
  output logic           dn_valid,
  input  logic           dn_ready,
  output qmm_pkg::mixed_t dn_mix
);
  import qmm_pkg::*;

  localparam int unsigned DQ_TOP = DQ_SHIFT + 4;
  localparam int unsigned DR_TOP = DR_SHIFT + 14;

  // stage 1: clamp, mix sums, sag test, whole part of drop / 3500
  logic             s1_v_r;
  logic [1:0]       s1_op_r;
  logic [11:0]      s1_thr_r;
  logic [3:0][14:0] s1_w_r;
  logic             s1_comp_r;
  logic [15:0]      s1_drop_r;
  logic [4:0]       s1_dq_r;

  // stage 2: magnitudes, remainder of drop / 3500
  logic             s2_v_r;
  logic [1:0]       s2_op_r;
  logic [11:0]      s2_thr_r;
  logic [3:0][14:0] s2_w_r;
  logic [3:0][13:0] s2_aw_r;
  logic [3:0]       s2_neg_r;
  logic             s2_comp_r;
  logic [11:0]      s2_dr_r;
  logic [4:0]       s2_dq_r;

  // stage 3: partial products
  logic             s3_v_r;
  logic [1:0]       s3_op_r;
  logic [11:0]      s3_thr_r;
  logic [3:0][14:0] s3_w_r;
  logic [3:0]       s3_neg_r;
  logic             s3_comp_r;
  logic [3:0][25:0] s3_a_r;
  logic [3:0][18:0] s3_b_r;

  // stage 4: correction magnitude
  logic             s4_v_r;
  logic [1:0]       s4_op_r;
  logic [11:0]      s4_thr_r;
  logic [3:0][14:0] s4_w_r;
  logic [3:0]       s4_neg_r;
  logic             s4_comp_r;
  logic [3:0][18:0] s4_mag_r;

  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !s4_v_r || dn_ready;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = s4_v_r;

  // stage 1 logic
  logic [11:0]        thr_c;
  logic signed [14:0] t_c, r_c, p_c, y_c;
  logic [3:0][14:0]   w_c;
  logic               comp_c;
  logic [15:0]        drop_c;
  logic [32:0]        dq_prod_c;

  always_comb begin
    thr_c = (up_item.throttle > cfg.throttle_limit) ? cfg.throttle_limit : up_item.throttle;
    t_c   = $signed({3'b000, thr_c});
    r_c   = $signed({{3{up_item.roll[11]}}, up_item.roll});
    p_c   = $signed({{3{up_item.pitch[11]}}, up_item.pitch});
    y_c   = $signed({{3{up_item.yaw[11]}}, up_item.yaw});
    w_c[0] = t_c - p_c + r_c - y_c;   // front right
    w_c[1] = t_c + p_c + r_c + y_c;   // front left
    w_c[2] = t_c + p_c - r_c - y_c;   // rear right
    w_c[3] = t_c - p_c - r_c + y_c;   // rear left
    comp_c    = (up_item.level < cfg.battery_full) && (up_item.level > cfg.battery_empty);
    drop_c    = cfg.battery_full - up_item.level;
    dq_prod_c = 33'(drop_c) * 33'(DQ_RECIP);
  end

  // stage 2 logic
  logic [16:0]      dqm_c;
  logic [16:0]      dr_c;
  logic [3:0][14:0] negw_c;
  logic [3:0][13:0] aw_c;

  always_comb begin
    dqm_c = 17'(s1_dq_r) * 17'(SAG_DIV_W);
    dr_c  = {1'b0, s1_drop_r} - dqm_c;
    for (int k = 0; k < MOTORS; k++) begin
      negw_c[k] = -s1_w_r[k];
      aw_c[k]   = s1_w_r[k][14] ? negw_c[k][13:0] : s1_w_r[k][13:0];
    end
  end

  // stage 4 logic: (a / 4) / 875 plus the whole-part product
  logic [3:0][48:0] c_prod_c;
  logic [3:0][18:0] mag_c;

  always_comb begin
    for (int k = 0; k < MOTORS; k++) begin
      c_prod_c[k] = 49'(s3_a_r[k][25:2]) * 49'(DR_RECIP);
      mag_c[k]    = s3_b_r[k] + {4'b0000, c_prod_c[k][DR_TOP:DR_SHIFT]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= up_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      s1_op_r   <= up_item.op;
      s1_thr_r  <= thr_c;
      s1_w_r    <= w_c;
      s1_comp_r <= comp_c;
      s1_drop_r <= drop_c;
      s1_dq_r   <= dq_prod_c[DQ_TOP:DQ_SHIFT];
    end
    if (rdy2 && s1_v_r) begin
      s2_op_r   <= s1_op_r;
      s2_thr_r  <= s1_thr_r;
      s2_w_r    <= s1_w_r;
      s2_comp_r <= s1_comp_r;
      s2_dr_r   <= dr_c[11:0];
      s2_dq_r   <= s1_dq_r;
      s2_aw_r   <= aw_c;
      for (int k = 0; k < MOTORS; k++) begin
        s2_neg_r[k] <= s1_w_r[k][14];
      end
    end
    if (rdy3 && s2_v_r) begin
      s3_op_r   <= s2_op_r;
      s3_thr_r  <= s2_thr_r;
      s3_w_r    <= s2_w_r;
      s3_neg_r  <= s2_neg_r;
      s3_comp_r <= s2_comp_r;
      for (int k = 0; k < MOTORS; k++) begin
        s3_a_r[k] <= 26'(s2_aw_r[k]) * 26'(s2_dr_r);
        s3_b_r[k] <= 19'(s2_aw_r[k]) * 19'(s2_dq_r);
      end
    end
    if (rdy4 && s3_v_r) begin
      s4_op_r   <= s3_op_r;
      s4_thr_r  <= s3_thr_r;
      s4_w_r    <= s3_w_r;
      s4_neg_r  <= s3_neg_r;
      s4_comp_r <= s3_comp_r;
      s4_mag_r  <= mag_c;
    end
  end

  always_comb begin
    dn_mix.op   = s4_op_r;
    dn_mix.thr  = s4_thr_r;
    dn_mix.w    = s4_w_r;
    dn_mix.mag  = s4_mag_r;
    dn_mix.neg  = s4_neg_r;
    dn_mix.comp = s4_comp_r;
  end

endmodule

[sv/quad_motor_mixer_pulse_gen.sv]
// Quad X motor mixer and ESC pulse generator.
//
// Input channel (in_valid / in_stall) carries one beat per operation: a
// one-microsecond tick, a mix of throttle and roll/pitch/yaw corrections, or
// a motor disable. Every input beat yields exactly one output beat
// (out_valid / out_stall) with the four pulse line levels, the frame start
// flag, the clamped throttle and the four commanded widths.
// From input beat to output beat a beat passes an input register, four
// arithmetic stages (mix sums, sag divide split, partial products,
// reciprocal divide by 3500) and the output register, where the widths are
// clamped and the width, latch and frame counter state is updated.
// Throughput is one beat per cycle while out_stall is low; the rate is set by
// the single-pass pipeline, each stage holds one beat.
// When out_stall is high the output beat holds and the pipeline fills; in_stall
// rises once every stage is occupied.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the commanded and
// latched widths and the frame counter, and restores the register defaults.
// The cfg port writes one register per cycle at cfg_we; write only while idle.
module quad_motor_mixer_pulse_gen (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [11:0]        in_throttle,
  input  logic [15:0]        in_battery_level,
  input  logic signed [11:0] in_roll_correction,
  input  logic signed [11:0] in_pitch_correction,
  input  logic signed [11:0] in_yaw_correction,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_line_front_right,
  output logic               out_line_front_left,
  output logic               out_line_rear_right,
  output logic               out_line_rear_left,
  output logic               out_frame_start,
  output logic [11:0]        out_throttle_used,
  output logic [11:0]        out_width_front_right,
  output logic [11:0]        out_width_front_left,
  output logic [11:0]        out_width_rear_right,
  output logic [11:0]        out_width_rear_left,

  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import qmm_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_limit   <= RST_THROTTLE_LIMIT;
      cfg_r.battery_full     <= RST_BATTERY_FULL;
      cfg_r.battery_empty    <= RST_BATTERY_EMPTY;
      cfg_r.motors_on_width  <= RST_MOTORS_ON_WIDTH;
      cfg_r.max_width        <= RST_MAX_WIDTH;
      cfg_r.motors_off_width <= RST_MOTORS_OFF_WIDTH;
      cfg_r.frame_period     <= RST_FRAME_PERIOD;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THROTTLE_LIMIT:   cfg_r.throttle_limit   <= cfg_wdata[11:0];
        CFG_BATTERY_FULL:     cfg_r.battery_full     <= cfg_wdata;
        CFG_BATTERY_EMPTY:    cfg_r.battery_empty    <= cfg_wdata;
        CFG_MOTORS_ON_WIDTH:  cfg_r.motors_on_width  <= cfg_wdata[11:0];
        CFG_MAX_WIDTH:        cfg_r.max_width        <= cfg_wdata[11:0];
        CFG_MOTORS_OFF_WIDTH: cfg_r.motors_off_width <= cfg_wdata[11:0];
        CFG_FRAME_PERIOD:     cfg_r.frame_period     <= cfg_wdata;
        default: ;  // index 7 is not a register
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic   s0_v_r;
  item_t  s0_item_r;
  logic   pipe_up_ready;
  logic   rdy0;

  assign rdy0     = !s0_v_r || pipe_up_ready;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (rdy0) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      s0_item_r.op       <= in_operation;
      s0_item_r.throttle <= in_throttle;
      s0_item_r.level    <= in_battery_level;
      s0_item_r.roll     <= in_roll_correction;
      s0_item_r.pitch    <= in_pitch_correction;
      s0_item_r.yaw      <= in_yaw_correction;
    end
  end

  // ---------------------------------------------------------------------
  // Mix and sag arithmetic, four stages
  // ---------------------------------------------------------------------
  logic   pipe_dn_valid;
  logic   out_ready;
  mixed_t mix;

  qmm_mix_pipe u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s0_v_r),
    .up_ready (pipe_up_ready),
    .up_item  (s0_item_r),
    .dn_valid (pipe_dn_valid),
    .dn_ready (out_ready),
    .dn_mix   (mix)
  );

  // ---------------------------------------------------------------------
  // Final stage: clamp, state update, pulse levels, output register
  // ---------------------------------------------------------------------
  logic [3:0][11:0] cmd_r, cmd_nxt;
  logic [3:0][11:0] lat_r, lat_nxt;
  logic [15:0]      fc_r, fc_nxt;

  logic             out_valid_r;
  logic [3:0]       out_line_r;
  logic             out_start_r;
  logic [11:0]      out_thr_r;
  logic [3:0][11:0] out_width_r;

  logic               fin;
  logic [3:0][19:0]   wf_c;
  logic [3:0][11:0]   clamp_c;
  logic [16:0]        fc_inc;
  logic               start_c;
  logic [11:0]        thr_used_c;
  logic [3:0]         line_c;
  logic signed [19:0] w_ext, m_ext;

  assign out_ready = !out_valid_r || !out_stall;
  assign fin       = pipe_dn_valid && out_ready;

  always_comb begin
    w_ext = '0;
    m_ext = '0;
    for (int k = 0; k < MOTORS; k++) begin
      w_ext = $signed({{5{mix.w[k][14]}}, mix.w[k]});
      m_ext = $signed({1'b0, mix.mag[k]});
      // correction truncates toward zero: magnitude carries the sign of w
      if (!mix.comp) begin
        wf_c[k] = w_ext;
      end else if (mix.neg[k]) begin
        wf_c[k] = w_ext - m_ext;
      end else begin
        wf_c[k] = w_ext + m_ext;
      end
      // lower limit tested first; if limits cross, widths not below it take max
      if ($signed(wf_c[k]) < $signed({8'd0, cfg_r.motors_on_width})) begin
        clamp_c[k] = cfg_r.motors_on_width;
      end else if ($signed(wf_c[k]) > $signed({8'd0, cfg_r.max_width})) begin
        clamp_c[k] = cfg_r.max_width;
      end else begin
        clamp_c[k] = wf_c[k][11:0];
      end
    end
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    lat_nxt    = lat_r;
    fc_nxt     = fc_r;
    start_c    = 1'b0;
    thr_used_c = '0;
    fc_inc     = {1'b0, fc_r} + 17'd1;
    case (op_t'(mix.op))
      OP_MIX: begin
        cmd_nxt    = clamp_c;
        thr_used_c = mix.thr;
      end
      OP_DISABLE: begin
        for (int k = 0; k < MOTORS; k++) begin
          cmd_nxt[k] = cfg_r.motors_off_width;
        end
      end
      OP_TICK: begin
        // frame boundary: latch the widths for the whole frame
        start_c = (fc_r == '0);
        if (start_c) begin
          lat_nxt = cmd_r;
        end
        // a period of zero acts as one; a shortened period wraps next tick
        fc_nxt = (fc_inc >= {1'b0, cfg_r.frame_period}) ? '0 : fc_inc[15:0];
      end
      default: ;  // unused code: state holds
    endcase
    // levels use the count before it advances
    for (int k = 0; k < MOTORS; k++) begin
      line_c[k] = {4'd0, lat_nxt[k]} > fc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cmd_r       <= '0;
      lat_r       <= '0;
      fc_r        <= '0;
    end else begin
      if (out_ready) out_valid_r <= pipe_dn_valid;
      if (fin) begin
        cmd_r <= cmd_nxt;
        lat_r <= lat_nxt;
        fc_r  <= fc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_line_r  <= line_c;
      out_start_r <= start_c;
      out_thr_r   <= thr_used_c;
      out_width_r <= cmd_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_line_front_right  = out_line_r[0];
  assign out_line_front_left   = out_line_r[1];
  assign out_line_rear_right   = out_line_r[2];
  assign out_line_rear_left    = out_line_r[3];
  assign out_frame_start       = out_start_r;
  assign out_throttle_used     = out_thr_r;
  assign out_width_front_right = out_width_r[0];
  assign out_width_front_left  = out_width_r[1];
  assign out_width_rear_right  = out_width_r[2];
  assign out_width_rear_left   = out_width_r[3];

endmodule

[tb/sv/mixer_checker.sv]
`timescale 1ns / 1ps

module mixer_checker (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [11:0]        in_throttle,
  input  logic [15:0]        in_battery_level,
  input  logic signed [11:0] in_roll_correction,
  input  logic signed [11:0] in_pitch_correction,
  input  logic signed [11:0] in_yaw_correction,

  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_line_front_right,
  input  logic               out_line_front_left,
  input  logic               out_line_rear_right,
  input  logic               out_line_rear_left,
  input  logic               out_frame_start,
  input  logic [11:0]        out_throttle_used,
  input  logic [11:0]        out_width_front_right,
  input  logic [11:0]        out_width_front_left,
  input  logic [11:0]        out_width_rear_right,
  input  logic [11:0]        out_width_rear_left,

  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,

  output int                 fail_count,
  output int                 due_count,
  output int                 compared_count,
  output int                 frame_start_count
);
  import qmm_pkg::*;

  // Motor order everywhere: front right, front left, rear right, rear left.
  typedef struct packed {
    logic [3:0]       line;
    logic             frame_start;
    logic [11:0]      throttle_used;
    logic [3:0][11:0] width;
  } esc_beat_t;

  cfg_t             regs;
  logic [3:0][11:0] commanded;
  logic [3:0][11:0] latched;
  logic [15:0]      frame_count;
  esc_beat_t        due_outputs [$];
  int               errors;
  int               compared;
  int               starts;

  string motor_name [4] = '{"front right", "front left", "rear right", "rear left"};

  initial begin
    errors            = 0;
    compared          = 0;
    starts            = 0;
    fail_count        = 0;
    due_count         = 0;
    compared_count    = 0;
    frame_start_count = 0;
  end

  // Sag scaling (truncates toward zero), then the on / max clamps.
  function automatic logic [11:0] shape_width(input longint raw, input logic [15:0] level);
    longint w;
    w = raw;
    if (level < regs.battery_full && level > regs.battery_empty)
      w = w + (w * (longint'(regs.battery_full) - longint'(level))) / longint'(SAG_DIVISOR);
    if (w < longint'(regs.motors_on_width))
      return regs.motors_on_width;
    if (w > longint'(regs.max_width))
      return regs.max_width;
    return w[11:0];
  endfunction

  task automatic predict_beat(input logic [1:0] op, input logic [11:0] thr,
                              input logic [15:0] level, input logic signed [11:0] roll,
                              input logic signed [11:0] pitch,
                              input logic signed [11:0] yaw, output esc_beat_t r);
    longint      t;
    longint      rl;
    longint      pt;
    longint      yw;
    logic [11:0] used;
    logic        start;
    logic [16:0] next_count;
    used  = '0;
    start = 1'b0;
    case (op)
      OP_MIX: begin
        used = (thr > regs.throttle_limit) ? regs.throttle_limit : thr;
        t  = longint'(used);
        rl = longint'(roll);
        pt = longint'(pitch);
        yw = longint'(yaw);
        commanded[0] = shape_width(t - pt + rl - yw, level);
        commanded[1] = shape_width(t + pt + rl + yw, level);
        commanded[2] = shape_width(t + pt - rl - yw, level);
        commanded[3] = shape_width(t - pt - rl + yw, level);
      end
      OP_DISABLE: begin
        for (int i = 0; i < 4; i++) commanded[i] = regs.motors_off_width;
      end
      OP_TICK: begin
        if (frame_count == '0) begin
          start   = 1'b1;
          latched = commanded;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) r.line[i] = (frame_count < latched[i]);
    r.frame_start   = start;
    r.throttle_used = used;
    r.width         = commanded;
    if (op == OP_TICK) begin
      next_count  = {1'b0, frame_count} + 17'd1;
      frame_count = (next_count >= {1'b0, regs.frame_period}) ? '0 : next_count[15:0];
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("checker: %s", what);
  endtask

  always @(posedge clk) begin : track
    esc_beat_t want;
    esc_beat_t seen;
    esc_beat_t fresh;
    if (!rst_n) begin
      regs.throttle_limit   = RST_THROTTLE_LIMIT;
      regs.battery_full     = RST_BATTERY_FULL;
      regs.battery_empty    = RST_BATTERY_EMPTY;
      regs.motors_on_width  = RST_MOTORS_ON_WIDTH;
      regs.max_width        = RST_MAX_WIDTH;
      regs.motors_off_width = RST_MOTORS_OFF_WIDTH;
      regs.frame_period     = RST_FRAME_PERIOD;
      commanded   = '0;
      latched     = '0;
      frame_count = '0;
      due_outputs.delete();
    end else begin
      // Results first: a beat accepted this edge cannot have its result yet.
      if (out_valid && !out_stall) begin
        seen.line          = {out_line_rear_left, out_line_rear_right,
                              out_line_front_left, out_line_front_right};
        seen.frame_start   = out_frame_start;
        seen.throttle_used = out_throttle_used;
        seen.width         = {out_width_rear_left, out_width_rear_right,
                              out_width_front_left, out_width_front_right};
        if (due_outputs.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (after %0d)",
                                    compared));
        end else begin
          want = due_outputs.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (seen.line[i] !== want.line[i])
              report_mismatch($sformatf("beat %0d: %s line got %0b expected %0b",
                                        compared, motor_name[i], seen.line[i],
                                        want.line[i]));
          end
          if (seen.frame_start !== want.frame_start)
            report_mismatch($sformatf("beat %0d: frame_start got %0b expected %0b",
                                      compared, seen.frame_start, want.frame_start));
          if (seen.throttle_used !== want.throttle_used)
            report_mismatch($sformatf("beat %0d: throttle_used got %0d expected %0d",
                                      compared, seen.throttle_used, want.throttle_used));
          for (int i = 0; i < 4; i++) begin
            if (seen.width[i] !== want.width[i])
              report_mismatch($sformatf("beat %0d: %s width got %0d expected %0d",
                                        compared, motor_name[i], seen.width[i],
                                        want.width[i]));
          end
          if (want.frame_start) starts++;
          compared++;
        end
      end
      if (in_valid && !in_stall) begin
        predict_beat(in_operation, in_throttle, in_battery_level, in_roll_correction,
                     in_pitch_correction, in_yaw_correction, fresh);
        due_outputs.push_back(fresh);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_THROTTLE_LIMIT:   regs.throttle_limit   = cfg_wdata[11:0];
          CFG_BATTERY_FULL:     regs.battery_full     = cfg_wdata;
          CFG_BATTERY_EMPTY:    regs.battery_empty    = cfg_wdata;
          CFG_MOTORS_ON_WIDTH:  regs.motors_on_width  = cfg_wdata[11:0];
          CFG_MAX_WIDTH:        regs.max_width        = cfg_wdata[11:0];
          CFG_MOTORS_OFF_WIDTH: regs.motors_off_width = cfg_wdata[11:0];
          CFG_FRAME_PERIOD:     regs.frame_period     = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count        <= errors;
    due_count         <= due_outputs.size();
    compared_count    <= compared;
    frame_start_count <= starts;
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import qmm_pkg::*;

  // Operation code 3 is not decoded by the block; it must leave state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int PIPE_LATENCY     = 6;       // input beat to output beat
  localparam int CYCLE_LIMIT      = 200000;  // watchdog bound on the whole run
  localparam int IDLE_PCT         = 28;      // idle cycles per hundred, each side
  localparam int RANDOM_PER_PHASE = 260;
  localparam int HOLD_OFF_CYCLES  = 250;     // receiver hold-off, fills the pipe

  localparam logic [11:0] CORR_MIN = 12'h800;  // -2048
  localparam logic [11:0] CORR_MAX = 12'h7FF;  // +2047

  logic               clk;
  logic               rst_n;

  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic [11:0]        in_throttle;
  logic [15:0]        in_battery_level;
  logic signed [11:0] in_roll_correction;
  logic signed [11:0] in_pitch_correction;
  logic signed [11:0] in_yaw_correction;

  logic               out_valid;
  logic               out_stall;
  logic               out_line_front_right;
  logic               out_line_front_left;
  logic               out_line_rear_right;
  logic               out_line_rear_left;
  logic               out_frame_start;
  logic [11:0]        out_throttle_used;
  logic [11:0]        out_width_front_right;
  logic [11:0]        out_width_front_left;
  logic [11:0]        out_width_rear_right;
  logic [11:0]        out_width_rear_left;

  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_wdata;

  int fail_count;
  int due_count;
  int compared_count;
  int frame_start_count;

  // Stimulus knobs for the sender and receiver processes, and run counters.
  int in_idle_pct;
  int out_idle_pct;
  int hold_request;
  int beats_sent;
  int settings_count;
  int cycle_count;

  // Sender's copy of the battery window, used to aim levels at its edges.
  logic [15:0] cur_full;
  logic [15:0] cur_empty;

  quad_motor_mixer_pulse_gen DUT (.*);

  // Watches both channels, predicts every result beat and compares it.
  mixer_checker chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result beat ends here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Receiver: random stall, or a long hold-off once asked for one. The
  // hold-off is counted down here so the sender keeps pushing meanwhile.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  // One input beat: optional idle gap first, then valid held until accepted.
  // Valid is decided before it rises and never looks at in_stall.
  task automatic send_beat(input logic [1:0] op, input logic [11:0] thr,
                           input logic [15:0] level, input logic [11:0] roll,
                           input logic [11:0] pitch, input logic [11:0] yaw);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_throttle         <= thr;
    in_battery_level    <= level;
    in_roll_correction  <= roll;
    in_pitch_correction <= pitch;
    in_yaw_correction   <= yaw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Block is idle once every predicted beat has come out. The checker's count
  // is registered, so the task waits on the clock before its first read.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_one(input cfg_idx_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [11:0] mt, input logic [15:0] full,
                            input logic [15:0] empty, input logic [11:0] on_w,
                            input logic [11:0] max_w, input logic [11:0] off_w,
                            input logic [15:0] period);
    wait_idle();
    write_one(CFG_THROTTLE_LIMIT, 16'(mt));
    write_one(CFG_BATTERY_FULL, full);
    write_one(CFG_BATTERY_EMPTY, empty);
    write_one(CFG_MOTORS_ON_WIDTH, 16'(on_w));
    write_one(CFG_MAX_WIDTH, 16'(max_w));
    write_one(CFG_MOTORS_OFF_WIDTH, 16'(off_w));
    write_one(CFG_FRAME_PERIOD, period);
    cfg_we    <= 1'b0;
    cur_full  = full;
    cur_empty = empty;
    settings_count++;
  endtask

  // Random beat: ticks dominate so frames roll over; levels are aimed at the
  // window edges often; corrections hit the extremes now and then.
  task automatic random_beat(input int thr_span, input int corr_span);
    logic [1:0]  op;
    logic [11:0] thr;
    logic [15:0] level;
    logic [11:0] corr [3];
    int          pick;
    int          v;
    pick = $urandom_range(0, 99);
    if (pick < 50)      op = OP_TICK;
    else if (pick < 82) op = OP_MIX;
    else if (pick < 92) op = OP_DISABLE;
    else                op = OP_UNUSED;
    case ($urandom_range(0, 7))
      0:       thr = 12'h000;
      1:       thr = 12'hFFF;
      default: thr = 12'($urandom_range(0, thr_span));
    endcase
    case ($urandom_range(0, 7))
      0: level = cur_empty;
      1: level = cur_empty + 16'd1;
      2: level = cur_full - 16'd1;
      3: level = cur_full;
      4: level = 16'h0000;
      5: level = 16'hFFFF;
      6: level = 16'($urandom);
      default: begin
        if (cur_full > cur_empty + 16'd1)
          level = 16'($urandom_range(int'(cur_empty) + 1, int'(cur_full) - 1));
        else
          level = 16'($urandom);
      end
    endcase
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 9))
        0:       corr[j] = CORR_MIN;
        1:       corr[j] = CORR_MAX;
        default: begin
          v       = int'($urandom_range(0, 2 * corr_span)) - corr_span;
          corr[j] = 12'(v);
        end
      endcase
    end
    send_beat(op, thr, level, corr[0], corr[1], corr[2]);
  endtask

  task automatic run_phase(input int count, input int thr_span, input int corr_span);
    repeat (count) random_beat(thr_span, corr_span);
  endtask

  initial begin : stimulus
    in_valid            = 1'b0;
    in_operation        = OP_TICK;
    in_throttle         = '0;
    in_battery_level    = '0;
    in_roll_correction  = '0;
    in_pitch_correction = '0;
    in_yaw_correction   = '0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_THROTTLE_LIMIT;
    cfg_wdata           = '0;
    rst_n               = 1'b0;
    in_idle_pct         = IDLE_PCT;
    out_idle_pct        = IDLE_PCT;
    hold_request        = 0;
    beats_sent          = 0;
    settings_count      = 0;
    cur_full            = RST_BATTERY_FULL;
    cur_empty           = RST_BATTERY_EMPTY;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, reset register values ----
    // first tick: counter at zero latches the all-zero widths, frame starts
    send_beat(OP_TICK, 12'd0, 16'd0, 12'd0, 12'd0, 12'd0);
    send_beat(OP_UNUSED, 12'd777, 16'd10000, 12'd5, 12'd6, 12'd7);
    // throttle above the throttle limit, no battery compensation at level 0
    send_beat(OP_MIX, 12'hFFF, 16'h0000, 12'd0, 12'd0, 12'd0);
    // zero throttle clamps up to motors-on, level above the window
    send_beat(OP_MIX, 12'h000, 16'hFFFF, 12'd0, 12'd0, 12'd0);
    // window edges: equal to empty is off, one above is on
    send_beat(OP_MIX, 12'd1500, 16'd9000, 12'd100, -12'sd50, 12'd25);
    send_beat(OP_MIX, 12'd1500, 16'd9001, -12'sd100, 12'd50, -12'sd25);
    // one below full is on, equal to full is off
    send_beat(OP_MIX, 12'd1200, 16'd12599, 12'd40, 12'd30, 12'd20);
    send_beat(OP_MIX, 12'd1200, 16'd12600, 12'd40, 12'd30, 12'd20);
    send_beat(OP_MIX, 12'd1800, 16'd10000, CORR_MAX, CORR_MAX, CORR_MAX);
    send_beat(OP_MIX, 12'd1800, 16'd10000, CORR_MIN, CORR_MIN, CORR_MIN);
    // negative raw widths compensated: quotient truncates toward zero
    send_beat(OP_MIX, 12'd0, 16'd10000, CORR_MIN, CORR_MAX, CORR_MIN);
    send_beat(OP_DISABLE, 12'd0, 16'd0, 12'd0, 12'd0, 12'd0);
    send_beat(OP_TICK, 12'd0, 16'd0, 12'd0, 12'd0, 12'd0);
    send_beat(OP_MIX, 12'd1700, 16'd11000, CORR_MAX, -12'sd300, 12'd10);
    send_beat(OP_TICK, 12'd0, 16'd0, 12'd0, 12'd0, 12'd0);
    send_beat(OP_UNUSED, 12'hFFF, 16'hFFFF, CORR_MIN, CORR_MAX, CORR_MIN);

    // crossed clamps (on above max), empty above full, period zero; the
    // counter is past zero here so the next tick wraps it
    write_regs(12'hFFF, 16'd10000, 16'd20000, 12'd1500, 12'd1200, 12'hFFF, 16'd0);
    send_beat(OP_TICK, 12'd0, 16'd0, 12'd0, 12'd0, 12'd0);
    send_beat(OP_TICK, 12'd0, 16'd0, 12'd0, 12'd0, 12'd0);
    send_beat(OP_MIX, 12'd1000, 16'd15000, 12'd0, 12'd0, 12'd0);
    send_beat(OP_MIX, 12'd1400, 16'd15000, 12'd0, 12'd0, 12'd0);
    send_beat(OP_MIX, 12'hFFF, 16'd15000, 12'd0, 12'd0, 12'd0);
    send_beat(OP_DISABLE, 12'd0, 16'd0, 12'd0, 12'd0, 12'd0);
    send_beat(OP_TICK, 12'd0, 16'd0, 12'd0, 12'd0, 12'd0);
    send_beat(OP_MIX, 12'hFFF, 16'd15000, CORR_MAX, CORR_MIN, CORR_MAX);

    // ---- random phases ----
    // widest clamps, widest battery window, one-tick frames
    write_regs(12'hFFF, 16'hFFFF, 16'h0000, 12'h000, 12'hFFF, 12'h000, 16'd1);
    run_phase(RANDOM_PER_PHASE, 4095, 2047);

    // crossed clamps, empty window (empty equals full)
    write_regs(12'd200, 16'd5000, 16'd5000, 12'd300, 12'd100, 12'hFFF, 16'd150);
    run_phase(RANDOM_PER_PHASE, 400, 300);

    // period zero, zero throttle cap, empty at top, everything clamped to max
    write_regs(12'd0, 16'd0, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'd0);
    run_phase(RANDOM_PER_PHASE, 4095, 2047);

    // longest frame: count climbs through small widths, lines toggle
    write_regs(12'd80, 16'd12600, 16'd9000, 12'd0, 12'd200, 12'd40, 16'hFFFF);
    run_phase(RANDOM_PER_PHASE, 120, 60);

    // short frame below the count reached above: ends on the next tick
    write_regs(12'd60, 16'd12600, 16'd9000, 12'd5, 12'd50, 12'd10, 16'd40);
    run_phase(RANDOM_PER_PHASE, 80, 40);

    // random settings; second round runs with no idling on either side and a
    // long receiver hold-off so the pipeline fills and in_stall rises
    for (int round = 0; round < 2; round++) begin
      begin : random_round
        int full_v;
        full_v = $urandom_range(8000, 65535);
        write_regs(12'($urandom_range(0, 600)), 16'(full_v),
                   16'($urandom_range(0, full_v)), 12'($urandom_range(0, 150)),
                   12'($urandom_range(0, 300)), 12'($urandom_range(0, 4095)),
                   16'($urandom_range(1, 300)));
        if (round == 1) begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
          if (round == 1 && n == 60) hold_request = HOLD_OFF_CYCLES;
          random_beat(600, 200);
        end
      end
    end

    // drain: every predicted beat out, then a few quiet cycles
    wait_idle();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("summary: %0d input beats over %0d register settings, %0d result beats checked",
             beats_sent, settings_count, compared_count);
    $display("summary: %0d frame starts, one %0d-cycle receiver hold-off, %0d mismatches",
             frame_start_count, HOLD_OFF_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/qmm_pkg.sv
sv/qmm_mix_pipe.sv
sv/quad_motor_mixer_pulse_gen.sv
tb/sv/mixer_checker.sv
tb/sv/testbench.sv
